/* design/rcsfd_pkg.sv */
// ----------------------------------------------------------------------------
// rcsfd_pkg
// Shared constants for the RC serial frame decoder.
// ----------------------------------------------------------------------------
package rcsfd_pkg;

    localparam int FRAME_LENGTH_DEF  = 16;
    localparam int CHANNEL_SLOTS_DEF = 8;

    localparam int HEADER_BYTES    = 2;
    localparam int VALUE_OFFSET    = 988;
    localparam logic [3:0] CHAN_FIELD_MASK = 4'hF;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS_IN_USE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_SHIFT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_MASK    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VALUE_SHIFT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_GAP_US    = 3'd4;

    localparam logic [3:0]  RST_CHANNELS_IN_USE = 4'd7;
    localparam logic [2:0]  RST_CHANNEL_SHIFT   = 3'd2;
    localparam logic [2:0]  RST_CHANNEL_MASK    = 3'd3;
    localparam logic [2:0]  RST_VALUE_SHIFT     = 3'd0;
    localparam logic [15:0] RST_FRAME_GAP_US    = 16'd2500;

endpackage

/* design/rc_serial_frame_decoder.sv */
// ----------------------------------------------------------------------------
// rc_serial_frame_decoder
// Serial RC receiver frame decoder: frame byte buffer and channel table in
// synchronous RAMs, decoded one byte pair at a time.
// ----------------------------------------------------------------------------
// A byte request goes to S_OUT and then to the output register; a read request goes S_TRD, S_OUT.
// A frame-completing byte first loops S_DRD/S_DWR once per byte pair after the header.
// Throughput: one request at a time, accepted while the previous result waits
// in the output register; decode rate is set by the frame RAM read loop.
// Reset clears control and channel-table valid bits and loads config defaults at once; no sweep.
// ----------------------------------------------------------------------------
module rc_serial_frame_decoder #(
    parameter int FRAME_LENGTH  = rcsfd_pkg::FRAME_LENGTH_DEF,
    parameter int CHANNEL_SLOTS = rcsfd_pkg::CHANNEL_SLOTS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rcsfd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rcsfd_pkg::CFG_DATA_W-1:0] cfg_data,

    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             mode,
    input  logic [7:0]                       rx_byte,
    input  logic [31:0]                      arrival_time_us,
    input  logic [2:0]                       read_channel,

    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [11:0]                      channel_value,
    output logic                             frame_done
);
    import rcsfd_pkg::*;

    localparam int IDX_W = $clog2(FRAME_LENGTH);
    localparam int CNT_W = $clog2(FRAME_LENGTH + 1);
    localparam int CH_W  = (CHANNEL_SLOTS > 1) ? $clog2(CHANNEL_SLOTS) : 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DRD  = 3'd1;
    localparam logic [2:0] S_DWR  = 3'd2;
    localparam logic [2:0] S_TRD  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]               state_reg, state_next;
    logic [3:0]               ch_in_use_reg;
    logic [2:0]               ch_shift_reg;
    logic [2:0]               ch_mask_reg;
    logic [2:0]               val_shift_reg;
    logic [15:0]              gap_reg;
    logic [CNT_W-1:0]         held_reg, held_next;
    logic [31:0]              last_reg;
    logic [CNT_W-1:0]         pos_reg, pos_next;
    logic [11:0]              res_value_reg, res_value_next;
    logic                     res_done_reg, res_done_next;
    logic                     rd_ok_reg;
    logic                     out_valid_reg;
    logic [11:0]              out_value_reg;
    logic                     out_done_reg;
    logic [CHANNEL_SLOTS-1:0] ct_valid_reg;

    logic [7:0]               frame_mem [FRAME_LENGTH];
    logic [7:0]               hi_q, lo_q;
    logic [11:0]              ct_mem [CHANNEL_SLOTS];
    logic [11:0]              ct_rdata_q;

    logic                     accept;
    logic                     load_out;
    logic [31:0]              elapsed;
    logic                     gap_hit;
    logic [CNT_W-1:0]         held_eff;
    logic                     fb_we;
    logic [IDX_W-1:0]         fb_waddr;
    logic [IDX_W-1:0]         rd_a, rd_b;
    logic [CNT_W-1:0]         pos_p1;
    logic [CNT_W:0]           pos_p3;
    logic [3:0]               rd_ch4;
    logic                     rd_in_range;
    logic [CH_W-1:0]          ct_raddr;
    logic [3:0]               chan;
    logic [10:0]              raw;
    logic [11:0]              dec_val;
    logic                     ct_we;
    logic [CH_W-1:0]          ct_waddr;

    assign cfg_ready     = 1'b1;
    assign in_ready      = (state_reg == S_IDLE);
    assign accept        = in_valid && in_ready;
    assign load_out      = (state_reg == S_OUT) && (!out_valid_reg || out_ready);
    assign out_valid     = out_valid_reg;
    assign channel_value = out_value_reg;
    assign frame_done    = out_done_reg;

    assign elapsed  = arrival_time_us - last_reg;
    assign gap_hit  = elapsed > {16'd0, gap_reg};
    assign held_eff = gap_hit ? '0 : held_reg;
    assign fb_we    = accept && !mode && (held_eff < CNT_W'(FRAME_LENGTH));
    assign fb_waddr = held_eff[IDX_W-1:0];

    assign pos_p1 = pos_reg + CNT_W'(1);
    assign pos_p3 = {1'b0, pos_reg} + (CNT_W+1)'(3);
    assign rd_a   = pos_reg[IDX_W-1:0];
    assign rd_b   = pos_p1[IDX_W-1:0];

    assign rd_ch4      = {1'b0, read_channel};
    assign rd_in_range = {1'b0, rd_ch4} < 5'(CHANNEL_SLOTS);
    assign ct_raddr    = rd_ch4[CH_W-1:0];

    assign chan     = 4'(hi_q >> ch_shift_reg) & CHAN_FIELD_MASK;
    assign raw      = {hi_q[2:0] & ch_mask_reg, lo_q} >> val_shift_reg;
    assign dec_val  = 12'(raw) + 12'(VALUE_OFFSET);
    assign ct_we    = (state_reg == S_DWR) && (chan < ch_in_use_reg)
                      && ({1'b0, chan} < 5'(CHANNEL_SLOTS));
    assign ct_waddr = chan[CH_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        held_next      = held_reg;
        pos_next       = pos_reg;
        res_value_next = res_value_reg;
        res_done_next  = res_done_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_value_next = '0;
                    res_done_next  = 1'b0;
                    if (mode)
                    begin
                        state_next = S_TRD;
                    end
                    else
                    begin
                        state_next = S_OUT;
                        held_next  = held_eff;
                        if (fb_we)
                        begin
                            held_next = held_eff + CNT_W'(1);
                            if (held_next == CNT_W'(FRAME_LENGTH))
                            begin
                                state_next = S_DRD;
                                pos_next   = CNT_W'(HEADER_BYTES);
                            end
                        end
                    end
                end
            end
            S_DRD:
            begin
                state_next = S_DWR;
            end
            S_DWR:
            begin
                if (pos_p3 < (CNT_W+1)'(FRAME_LENGTH))
                begin
                    pos_next   = pos_reg + CNT_W'(2);
                    state_next = S_DRD;
                end
                else
                begin
                    res_done_next = 1'b1;
                    state_next    = S_OUT;
                end
            end
            S_TRD:
            begin
                res_value_next = rd_ok_reg ? ct_rdata_q : '0;
                state_next     = S_OUT;
            end
            S_OUT:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ch_in_use_reg <= RST_CHANNELS_IN_USE;
            ch_shift_reg  <= RST_CHANNEL_SHIFT;
            ch_mask_reg   <= RST_CHANNEL_MASK;
            val_shift_reg <= RST_VALUE_SHIFT;
            gap_reg       <= RST_FRAME_GAP_US;
            held_reg      <= '0;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
            ct_valid_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            held_reg  <= held_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_CHANNELS_IN_USE: ch_in_use_reg <= cfg_data[3:0];
                    CFG_CHANNEL_SHIFT:   ch_shift_reg  <= cfg_data[2:0];
                    CFG_CHANNEL_MASK:    ch_mask_reg   <= cfg_data[2:0];
                    CFG_VALUE_SHIFT:     val_shift_reg <= cfg_data[2:0];
                    CFG_FRAME_GAP_US:    gap_reg       <= cfg_data;
                    default:             ;
                endcase
            end
            if (accept && !mode)
            begin
                last_reg <= arrival_time_us;
            end
            if (ct_we)
            begin
                ct_valid_reg[ct_waddr] <= 1'b1;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg       <= pos_next;
        res_value_reg <= res_value_next;
        res_done_reg  <= res_done_next;
        if (accept)
        begin
            rd_ok_reg <= rd_in_range && ct_valid_reg[ct_raddr];
        end
        if (load_out)
        begin
            out_value_reg <= res_value_reg;
            out_done_reg  <= res_done_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fb_we)
        begin
            frame_mem[fb_waddr] <= rx_byte;
        end
        hi_q <= frame_mem[rd_a];
        lo_q <= frame_mem[rd_b];
    end

    always_ff @(posedge clk)
    begin
        if (ct_we)
        begin
            ct_mem[ct_waddr] <= dec_val;
        end
        ct_rdata_q <= ct_mem[ct_raddr];
    end

`ifndef ASSERT_OFF
    a_dwr_after_drd: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DWR |-> $past(state_reg) == S_DRD)
        else $error("decode write without preceding read");

    a_read_goes_trd: assert property (@(posedge clk) disable iff (!rst_n)
        accept && mode |=> state_reg == S_TRD)
        else $error("read request did not enter table read");

    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= CNT_W'(FRAME_LENGTH))
        else $error("byte count beyond frame length");

    a_done_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        load_out && res_done_reg |-> held_reg == CNT_W'(FRAME_LENGTH))
        else $error("frame done without full frame");
`endif

endmodule
